### design/http_first_segment_detector_defines.svh
// ----------------------------------------------------------------------------
// HTTP first segment detector assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef HTTP_FIRST_SEGMENT_DETECTOR_DEFINES_SVH
`define HTTP_FIRST_SEGMENT_DETECTOR_DEFINES_SVH

// Property that must hold at every clock edge out of reset.
`define HFSD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define HFSD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/hfsd_pkg.sv
// ----------------------------------------------------------------------------
// HTTP first segment detector package
// Method table, character codes and the per-segment state type.
// ----------------------------------------------------------------------------
package hfsd_pkg;

	localparam int METHOD_COUNT = 26;
	localparam int WORD_MAX     = 12;
	localparam int WORD_BITS    = WORD_MAX * 8;

	localparam logic [3:0] POS_MAX  = 4'd15;
	localparam logic [3:0] DEEP_MAX = 4'd9;

	localparam logic [7:0] CHAR_CR   = 8'h0D;
	localparam logic [7:0] CHAR_LF   = 8'h0A;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_ONE  = 8'h31;

	// "HTTP/1." with the first character in the top byte.
	localparam logic [55:0] VERSION_HEAD = "HTTP/1.";

	// Server rule fires while the eighth byte of the segment is taken.
	localparam logic [3:0] SERVER_DIGIT_POS = 4'd7;

	// Words are right-justified: the last character sits in the low byte.
	localparam logic [WORD_BITS-1:0] METHOD_TEXT [METHOD_COUNT] = '{
		"DELETE ", "GET ", "HEAD ", "POST ", "PUT ",
		"CONNECT ", "OPTIONS ", "TRACE ",
		"COPY ", "LOCK ", "MKCOL ", "MOVE ", "PROPFIND ", "PROPPATCH ",
		"SEARCH ", "UNLOCK ",
		"REPORT ", "MKACTIVITY ", "CHECKOUT ", "MERGE ",
		"MSEARCH ", "NOTIFY ", "SUBSCRIBE ", "UNSUBSCRIBE ",
		"PATCH ", "PURGE "
	};

	localparam logic [3:0] METHOD_LEN [METHOD_COUNT] = '{
		4'd7, 4'd4, 4'd5, 4'd5, 4'd4,
		4'd8, 4'd8, 4'd6,
		4'd5, 4'd5, 4'd6, 4'd5, 4'd9, 4'd10,
		4'd7, 4'd7,
		4'd7, 4'd11, 4'd9, 4'd6,
		4'd8, 4'd7, 4'd10, 4'd12,
		4'd6, 4'd6
	};

	typedef struct packed {
		logic [3:0]              pos;
		logic [METHOD_COUNT-1:0] cand;
		logic [3:0]              plen;
		logic [3:0]              deep;
		logic                    found;
	} seg_state_t;

	localparam seg_state_t SEG_RESET = '{
		pos:   4'd0,
		cand:  {METHOD_COUNT{1'b1}},
		plen:  4'd0,
		deep:  4'd0,
		found: 1'b0
	};

	// Character p of method m; only called with p below the word length.
	function automatic logic [7:0] method_char(input logic [4:0] m, input logic [3:0] p);
		logic [3:0] idx;
		idx = METHOD_LEN[m] - 4'd1 - p;
		return METHOD_TEXT[m][idx*8 +: 8];
	endfunction

	function automatic logic is_digit01(input logic [7:0] c);
		return (c == CHAR_ZERO) || (c == CHAR_ONE);
	endfunction

endpackage

### design/hfsd_match.sv
// ----------------------------------------------------------------------------
// HTTP first segment detector match logic
// Updates the segment state for one byte and forms the running verdict.
// ----------------------------------------------------------------------------
module hfsd_match import hfsd_pkg::*; (
	input  seg_state_t       seg,
	input  logic [8:0][7:0]  recent,
	input  logic [7:0]       data_byte,
	input  logic             from_server,
	input  logic             first_byte,
	input  logic             last_byte,
	output seg_state_t       seg_next,
	output logic             verdict
);

	seg_state_t cur;
	seg_state_t upd;
	logic       client_hit;
	logic       server_hit;

	always_comb begin
		cur = first_byte ? SEG_RESET : seg;
		upd = cur;

		// Lowest numbered method wins when the prefix completes; it is assigned last.
		if (cur.pos < POS_MAX) begin
			for (int m = METHOD_COUNT - 1; m >= 0; m--) begin
				if (cur.cand[5'(m)] && (cur.pos < METHOD_LEN[5'(m)])) begin
					if (method_char(5'(m), cur.pos) != data_byte) begin
						upd.cand[5'(m)] = 1'b0;
					end else if ((cur.pos + 4'd1 == METHOD_LEN[5'(m)]) &&
							(cur.plen == 4'd0)) begin
						upd.plen = METHOD_LEN[5'(m)];
					end
				end
			end
		end

		// LF now, CR before it, a 0 or 1 digit before that, and the version string in the seven bytes ahead of the digit.
		client_hit = !from_server && (upd.plen != 4'd0) && (data_byte == CHAR_LF) &&
			({1'b0, cur.pos} >= {1'b0, upd.plen} + 5'd1) && (cur.deep == DEEP_MAX) &&
			(recent[0] == CHAR_CR) && is_digit01(recent[1]) &&
			(recent[8:2] == VERSION_HEAD);

		server_hit = from_server && (cur.pos == SERVER_DIGIT_POS) && is_digit01(data_byte) &&
			(recent[6:0] == VERSION_HEAD);

		upd.found = cur.found | client_hit | server_hit;
		if (cur.deep < DEEP_MAX) begin
			upd.deep = cur.deep + 4'd1;
		end
		if (cur.pos < POS_MAX) begin
			upd.pos = cur.pos + 4'd1;
		end
	end

	assign verdict  = upd.found;
	assign seg_next = last_byte ? SEG_RESET : upd;

endmodule

### design/hfsd_out_reg.sv
// ----------------------------------------------------------------------------
// HTTP first segment detector result register
// Holds one verdict word until the downstream side takes it.
// ----------------------------------------------------------------------------
module hfsd_out_reg (
	input  logic clk,
	input  logic arst_n,
	input  logic load_valid,
	output logic load_ready,
	input  logic load_bit,
	output logic result_valid,
	input  logic result_ready,
	output logic is_http
);

	logic valid_q;
	logic bit_q;

	assign load_ready = !valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load_ready) begin
			valid_q <= load_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_ready && load_valid) begin
			bit_q <= load_bit;
		end
	end

	assign result_valid = valid_q;
	assign is_http      = bit_q;

endmodule

### design/http_first_segment_detector.sv
// ----------------------------------------------------------------------------
// HTTP first segment detector
// Byte-serial check of a stream segment for an HTTP request or status line.
// ----------------------------------------------------------------------------
// One byte word is taken per cycle, back to back. Each byte is registered,
// matched against all method words and the version patterns by combinational
// parallel compares, and the segment state is updated as it leaves the
// input register. A word with last_byte set yields one is_http word, loaded
// into the result register as it leaves the input register; other bytes
// yield nothing. The input side stalls only when a last byte is held while
// the result register is still full.
module http_first_segment_detector import hfsd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       data_valid,
	output logic       data_ready,
	input  logic [7:0] data_byte,
	input  logic       from_server,
	input  logic       first_byte,
	input  logic       last_byte,
	output logic       result_valid,
	input  logic       result_ready,
	output logic       is_http
);

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       server_s1;
	logic       first_s1;
	logic       last_s1;

	seg_state_t      seg_q;
	seg_state_t      seg_next;
	logic [8:0][7:0] recent_q;
	logic            verdict;
	logic            load_ready;
	logic            advance_s1;

	// Non-final bytes never wait on the result side.
	assign advance_s1 = valid_s1 && (!last_s1 || load_ready);
	assign data_ready = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (data_ready) begin
			valid_s1 <= data_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (data_valid && data_ready) begin
			data_s1   <= data_byte;
			server_s1 <= from_server;
			first_s1  <= first_byte;
			last_s1   <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q <= SEG_RESET;
		end else if (advance_s1) begin
			seg_q <= seg_next;
		end
	end

	// History bytes are only used once the segment byte counts (deep, pos) say they are valid.
	always_ff @(posedge clk) begin
		if (advance_s1) begin
			recent_q <= {recent_q[7:0], data_s1};
		end
	end

	hfsd_match u_match (
		.seg         (seg_q),
		.recent      (recent_q),
		.data_byte   (data_s1),
		.from_server (server_s1),
		.first_byte  (first_s1),
		.last_byte   (last_s1),
		.seg_next    (seg_next),
		.verdict     (verdict)
	);

	hfsd_out_reg u_out_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.load_valid   (valid_s1 && last_s1),
		.load_ready   (load_ready),
		.load_bit     (verdict),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.is_http      (is_http)
	);

endmodule

### design/hfsd_checker.sv
// ----------------------------------------------------------------------------
// HTTP first segment detector checker
// Port-level assertions on flow and result accounting, bound to the top level.
// ----------------------------------------------------------------------------
`include "http_first_segment_detector_defines.svh"

module hfsd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       data_valid,
	input logic       data_ready,
	input logic       last_byte,
	input logic       result_valid,
	input logic       result_ready,
	input logic       is_http
);

	logic [1:0] pending_q;
	logic       take_last;
	logic       give_result;

	assign take_last   = data_valid && data_ready && last_byte;
	assign give_result = result_valid && result_ready;

	// Final bytes taken whose verdict word has not yet been delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 2'd0;
		end else if (take_last && !give_result) begin
			pending_q <= pending_q + 2'd1;
		end else if (give_result && !take_last) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	`HFSD_ASSERT_NEXT(a_result_held, result_valid && !result_ready, result_valid && $stable(is_http), "result word changed or dropped while stalled")
	`HFSD_ASSERT(a_no_spurious_result, !result_valid || (pending_q != 2'd0), "result word without a final byte")
	`HFSD_ASSERT(a_pending_bound, pending_q <= 2'd2, "more verdicts in flight than stages")
	`HFSD_ASSERT(a_ready_when_drained, result_valid || data_ready, "input stalled while result side is empty")

endmodule

bind http_first_segment_detector hfsd_checker u_checker (.*);
